// ===== sv/assert_macros.svh =====
// Assertion macros for the voxel store RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define PVS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== sv/pvs_pkg.sv =====
// Types and constants for the packed voxel store.
// No dependencies.
package pvs_pkg;

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_SET_BLOCK = 3'd1;
  localparam logic [2:0] OP_SET_RAW   = 3'd2;
  localparam logic [2:0] OP_SET_LIGHT = 3'd3;
  localparam logic [2:0] OP_ACK       = 3'd4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAWNER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCHANT = 2'd1;

  localparam logic [7:0] SPAWNER_RESET = 8'd52;
  localparam logic [7:0] ENCHANT_RESET = 8'd116;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] x_pos;
    logic [3:0] y_pos;
    logic [3:0] z_pos;
    logic [7:0] block_type;
    logic [3:0] meta_nibble;
    logic [3:0] sky_level;
    logic [3:0] torch_level;
    logic [7:0] light_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_type;
    logic [3:0] read_meta;
    logic [3:0] read_sky;
    logic [3:0] read_torch;
    logic [5:0] face_mask;
    logic       rebuild_pending;
    logic       spawner_present;
    logic       enchant_present;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           value;
  } cfg_t;

  // One stored voxel: type byte, light byte (torch high nibble), metadata nibble.
  typedef struct packed {
    logic [7:0] vtype;
    logic [7:0] light;
    logic [3:0] meta;
  } voxel_t;

  typedef struct packed {
    logic rebuild;
    logic spawner;
    logic enchant;
  } flags_t;

  // Write request from the update logic to the store.
  typedef struct packed {
    logic   we;
    voxel_t wdata;
  } wr_t;

endpackage

// ===== sv/pvs_chan_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// Payload types come from pvs_pkg.
interface pvs_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pvs_merge.sv =====
// Update logic: merges one request into the voxel word read from the store,
// builds the response and the next flag values. Uses pvs_pkg.
module pvs_merge import pvs_pkg::*; #(
  parameter int EDGE = 16
) (
  input  req_t   req,
  input  logic   in_grid,
  input  voxel_t rd_word,
  input  flags_t flags,
  input  logic [7:0] spawner_code,
  input  logic [7:0] enchant_code,
  output wr_t    wr,
  output rsp_t   rsp,
  output flags_t flags_nxt
);

  localparam logic [5:0] LAST = 6'(EDGE - 1);

  logic   is_set;
  logic   is_light;
  logic   marks;
  voxel_t word_new;
  logic [5:0] faces;

  assign is_set   = (req.operation == OP_SET_BLOCK) || (req.operation == OP_SET_RAW);
  assign is_light = (req.operation == OP_SET_LIGHT);
  // Set block and set light flag a rebuild; raw set stays quiet.
  assign marks    = in_grid &&
                    ((req.operation == OP_SET_BLOCK) || (req.operation == OP_SET_LIGHT));

  always_comb begin
    word_new = rd_word;
    if (in_grid && is_set) begin
      word_new.vtype = req.block_type;
      word_new.light = {req.torch_level, req.sky_level};
      word_new.meta  = req.meta_nibble;
    end else if (in_grid && is_light) begin
      word_new.light = req.light_byte;
    end
  end

  assign wr.we    = in_grid && (is_set || is_light);
  assign wr.wdata = word_new;

  assign faces = {(6'(req.z_pos) == LAST), (req.z_pos == 4'd0),
                  (6'(req.y_pos) == LAST), (req.y_pos == 4'd0),
                  (6'(req.x_pos) == LAST), (req.x_pos == 4'd0)};

  always_comb begin
    flags_nxt = flags;
    if (req.operation == OP_ACK) begin
      flags_nxt.rebuild = 1'b0;
    end
    if (marks) begin
      flags_nxt.rebuild = 1'b1;
    end
    if (in_grid && is_set && (req.block_type == spawner_code)) begin
      flags_nxt.spawner = 1'b1;
    end
    if (in_grid && is_set && (req.block_type == enchant_code)) begin
      flags_nxt.enchant = 1'b1;
    end
  end

  always_comb begin
    rsp.read_type       = in_grid ? word_new.vtype : 8'd0;
    rsp.read_meta       = in_grid ? word_new.meta : 4'd0;
    rsp.read_sky        = in_grid ? word_new.light[3:0] : 4'd0;
    rsp.read_torch      = in_grid ? word_new.light[7:4] : 4'd0;
    rsp.face_mask       = marks ? faces : 6'd0;
    rsp.rebuild_pending = flags_nxt.rebuild;
    rsp.spawner_present = flags_nxt.spawner;
    rsp.enchant_present = flags_nxt.enchant;
  end

endmodule

// ===== sv/packed_voxel_store.sv =====
// Packed voxel store top level: voxel memory, control sequencer, flags, config.
// Depends on pvs_pkg, pvs_chan_if, pvs_merge and assert_macros.svh.
//
//   channel   dir  payload   handshake
//   in_bus    in   req_t     valid/ready, one request per voxel operation
//   out_bus   out  rsp_t     valid/ready, one response per request
//   cfg_bus   in   cfg_t     valid/ready, always ready
//
// Each request is a read of the voxel word if inside the grid, then the merge with a
// write-back for set operations, and the response loaded into the output register.
// After reset a clearing pass writes air to all EDGE**3 words; requests are held off
// until it ends, config writes are taken. A full output register that is not being read
// stalls the write-back; no new request enters then.
`include "assert_macros.svh"
module packed_voxel_store import pvs_pkg::*; #(
  parameter int EDGE = 16
) (
  input logic clk,
  input logic rst_n,
  pvs_chan_if.sink   in_bus,
  pvs_chan_if.source out_bus,
  pvs_chan_if.sink   cfg_bus
);

  localparam int VOXELS = EDGE * EDGE * EDGE;
  localparam int AW     = $clog2(VOXELS);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MOD} state_t;

  state_t state_r;
  logic [AW-1:0] clr_cnt_r;
  logic   out_valid_r;
  rsp_t   out_data_r;
  flags_t flags_r;
  logic [7:0] spawner_code_r;
  logic [7:0] enchant_code_r;

  req_t   req_r;
  logic   inside_r;
  logic [AW-1:0] addr_r;
  voxel_t rd_word_r;
  voxel_t mem [VOXELS];

  logic   in_take;
  logic   in_inside;
  logic [15:0] vox_idx;
  logic [AW-1:0] in_addr;
  logic   commit;
  logic   mem_we;
  logic [AW-1:0] mem_waddr;
  voxel_t mem_wdata;
  wr_t    upd_wr;
  rsp_t   upd_rsp;
  flags_t flags_nxt;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  assign in_take   = in_bus.valid && in_bus.ready;
  assign in_inside = (32'(in_bus.data.x_pos) < EDGE) && (32'(in_bus.data.y_pos) < EDGE) &&
                     (32'(in_bus.data.z_pos) < EDGE);
  // v = x + (z + y*EDGE)*EDGE
  assign vox_idx = 16'(in_bus.data.x_pos) +
                   16'(EDGE) * (16'(in_bus.data.z_pos) + 16'(EDGE) * 16'(in_bus.data.y_pos));
  assign in_addr = vox_idx[AW-1:0];

  assign commit = (state_r == ST_MOD) && (!out_valid_r || out_bus.ready);

  pvs_merge #(.EDGE(EDGE)) u_merge (
    .req          (req_r),
    .in_grid      (inside_r),
    .rd_word      (rd_word_r),
    .flags        (flags_r),
    .spawner_code (spawner_code_r),
    .enchant_code (enchant_code_r),
    .wr           (upd_wr),
    .rsp          (upd_rsp),
    .flags_nxt    (flags_nxt)
  );

  assign mem_we    = (state_r == ST_CLEAR) || (commit && upd_wr.we);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : upd_wr.wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_take && in_inside) begin
      rd_word_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r    <= in_bus.data;
      inside_r <= in_inside;
      addr_r   <= in_addr;
    end
    if (commit) begin
      out_data_r <= upd_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      flags_r        <= '0;
      spawner_code_r <= SPAWNER_RESET;
      enchant_code_r <= ENCHANT_RESET;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        unique case (cfg_bus.data.index)
          CFG_SPAWNER: begin
            spawner_code_r <= cfg_bus.data.value;
          end
          CFG_ENCHANT: begin
            enchant_code_r <= cfg_bus.data.value;
          end
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_bus.ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(VOXELS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          // hold until the output register is free or being read
          if (commit) begin
            out_valid_r <= 1'b1;
            flags_r     <= flags_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `PVS_ASSERT_NEXT(a_take_enters_mod, in_take, state_r == ST_MOD, "request not in write-back")
  `PVS_ASSERT_NEXT(a_commit_shows, commit, out_valid_r, "committed response not presented")
  `PVS_ASSERT(a_rise_after_mod, $rose(out_valid_r) |-> ($past(state_r) == ST_MOD), "stray response")

endmodule
